/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL. They sample on aclk and are
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the following cycle.
`define SWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/swarq_pkg.sv */
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types, codes and widths of the selective-repeat ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int MAX_PACKETS_DEF = 64;

    // Stream widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Request kinds.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ACK   = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result actions.
    localparam logic [1:0] ACT_SEND   = 2'd0;
    localparam logic [1:0] ACT_RESEND = 2'd1;
    localparam logic [1:0] ACT_DONE   = 2'd2;
    localparam logic [1:0] ACT_FAIL   = 2'd3;

    // Message phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  pkt;
        logic [15:0] tag;
        logic        first;
    } result_t;

endpackage

/* rtl/sliding_window_arq_sender.sv */
// ----------------------------------------------------------------------------
// sliding_window_arq_sender
// Control path of a selective-repeat ARQ sender with a packet status memory.
// ----------------------------------------------------------------------------
// A start transaction runs the start-index modulo, or reports done for zero
// packets. An acknowledgement reads and evaluates the acked packet's status,
// then may run the modulo and scan status entries to refill the window.
// A tick reads each packet of the message in turn, then does timeout accounting.
// Each scan step reads the single status memory and then evaluates the entry.
// Reset (aresetn low, synchronous) clears the message state, the status
// valid bits and restores window_size 4 and timeout_limit 3.
module sliding_window_arq_sender #(
    parameter int MAX_PACKETS = swarq_pkg::MAX_PACKETS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: packet_count[6:0], search_start[12:7], ack_packet[18:13],
    //        ack_msg_id[34:19], zero padding above.
    input  logic [swarq_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: req_type[1:0].
    input  logic [swarq_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: packet_index[5:0], msg_tag[21:6], zero padding above.
    output logic [swarq_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser: action[1:0], first_flag[2].
    output logic [swarq_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tlast,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swarq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swarq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Count width holds 0..MAX_PACKETS, index width addresses the memory.
    localparam int CW   = $clog2(MAX_PACKETS + 1);
    localparam int IW   = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int CMPW = (CW > 7) ? CW : 7;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;  // start index modulo the count
    localparam logic [2:0] ST_ACK_RD = 3'd2;  // read status of the acked packet
    localparam logic [2:0] ST_ACK_EV = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;  // read one status entry of a scan
    localparam logic [2:0] ST_EVAL   = 3'd5;
    localparam logic [2:0] ST_TAIL   = 3'd6;  // timeout accounting after a tick
    localparam logic [2:0] ST_FINISH = 3'd7;  // flush the held result as last

    localparam logic [2:0] MOD_LAST = 3'd5;

    // Packet status memory: bit 1 acked, bit 0 sent. A clear valid bit
    // makes an entry read as all zero.
    logic [1:0]             mem [MAX_PACKETS];
    logic [MAX_PACKETS-1:0] vld_reg, vld_next;
    logic [1:0]             rd_data_reg;
    logic                   rd_vld_reg;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [1:0]             mem_wdata;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] acked_cnt_reg, acked_cnt_next;
    logic [6:0]    credits_reg, credits_next;
    logic [15:0]   tag_reg, tag_next;
    logic [3:0]    tmo_reg, tmo_next;
    logic [IW-1:0] first_idx_reg, first_idx_next;
    logic [6:0]    window_reg, window_next;
    logic [3:0]    limit_reg, limit_next;

    // Latched request.
    logic [1:0]    req_reg, req_next;
    logic [5:0]    sstart_reg, sstart_next;
    logic [5:0]    apkt_reg, apkt_next;
    logic [15:0]   aid_reg, aid_next;

    // Scan and modulo state.
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0] mod_r_reg, mod_r_next;
    logic [5:0]    mod_dvd_reg, mod_dvd_next;
    logic [2:0]    mod_step_reg, mod_step_next;

    // One result is held back until the next one, or the end of the
    // transaction, tells whether it is the last.
    logic                    pend_valid_reg, pend_valid_next;
    swarq_pkg::result_t      pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    swarq_pkg::result_t      out_reg, out_next;
    logic                    out_last_reg, out_last_next;

    // Combinational helpers.
    logic [1:0]          in_req;
    logic [6:0]          in_count;
    logic [CW-1:0]       count_sat;
    logic [6:0]          win_eff;
    logic [CW:0]         mod_trial;
    logic [CW-1:0]       pos_p1;
    logic [IW-1:0]       pos_wrap;
    logic                ent_sent;
    logic                ent_acked;
    logic                apkt_in_range;
    logic                hit;
    logic [CW:0]         acked_p1;
    logic [3:0]          tmo_inc;
    logic                out_free;
    logic                can_emit;
    logic                emit_go;
    logic                flush_go;
    swarq_pkg::result_t  emit_res;

    assign in_req    = s_tuser[1:0];
    assign in_count  = s_tdata[6:0];
    assign count_sat = (CMPW'(in_count) > CMPW'(MAX_PACKETS)) ? CW'(MAX_PACKETS)
                                                             : CW'(in_count);
    assign win_eff   = (window_reg == 7'd0) ? 7'd1 : window_reg;
    assign mod_trial = {mod_r_reg, mod_dvd_reg[5]};
    assign pos_p1    = CW'(pos_reg) + CW'(1);
    assign pos_wrap  = (pos_p1 == total_reg) ? '0 : IW'(pos_p1);
    assign ent_sent  = rd_vld_reg & rd_data_reg[0];
    assign ent_acked = rd_vld_reg & rd_data_reg[1];
    assign apkt_in_range = CMPW'(apkt_reg) < CMPW'(total_reg);
    assign acked_p1  = (CW + 1)'(acked_cnt_reg) + (CW + 1)'(1);
    assign tmo_inc   = (tmo_reg == 4'd15) ? 4'd15 : tmo_reg + 4'd1;
    assign out_free  = !out_valid_reg || m_tready;
    assign can_emit  = !pend_valid_reg || out_free;

    assign hit = ((phase_reg == swarq_pkg::PH_FIRST) && apkt_in_range && !ent_acked &&
                  (CMPW'(apkt_reg) == CMPW'(first_idx_reg))) ||
                 ((phase_reg == swarq_pkg::PH_RUN) && apkt_in_range && ent_sent &&
                  !ent_acked && (aid_reg == tag_reg));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_reg.tag, out_reg.pkt};
    assign m_tuser   = {out_reg.first, out_reg.action};
    assign m_tlast   = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        total_next     = total_reg;
        acked_cnt_next = acked_cnt_reg;
        credits_next   = credits_reg;
        tag_next       = tag_reg;
        tmo_next       = tmo_reg;
        first_idx_next = first_idx_reg;
        window_next    = window_reg;
        limit_next     = limit_reg;
        req_next       = req_reg;
        sstart_next    = sstart_reg;
        apkt_next      = apkt_reg;
        aid_next       = aid_reg;
        pos_next       = pos_reg;
        scan_cnt_next  = scan_cnt_reg;
        mod_r_next     = mod_r_reg;
        mod_dvd_next   = mod_dvd_reg;
        mod_step_next  = mod_step_reg;
        vld_next       = vld_reg;
        pend_valid_next = pend_valid_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = 2'b00;
        emit_go        = 1'b0;
        flush_go       = 1'b0;
        emit_res       = '0;

        // Restoring division step: one remainder bit a cycle.
        if (mod_trial >= (CW + 1)'(total_reg)) begin
            mod_r_next = CW'(mod_trial - (CW + 1)'(total_reg));
        end else begin
            mod_r_next = CW'(mod_trial);
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                swarq_pkg::CFG_WINDOW:  window_next = cfg_data[6:0];
                swarq_pkg::CFG_TIMEOUT: limit_next  = cfg_data[3:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                mod_r_next = mod_r_reg;
                if (s_tvalid) begin
                    req_next    = in_req;
                    sstart_next = s_tdata[12:7];
                    apkt_next   = s_tdata[18:13];
                    aid_next    = s_tdata[34:19];
                    unique case (in_req)
                        swarq_pkg::REQ_START: begin
                            vld_next       = '0;
                            acked_cnt_next = '0;
                            tag_next       = '0;
                            tmo_next       = '0;
                            total_next     = count_sat;
                            if (count_sat == '0) begin
                                credits_next = '0;
                                phase_next   = swarq_pkg::PH_IDLE;
                                emit_go      = 1'b1;
                                emit_res     = '{swarq_pkg::ACT_DONE, 6'd0, 16'd0, 1'b0};
                                state_next   = ST_FINISH;
                            end else begin
                                credits_next = (CMPW'(count_sat) < CMPW'(win_eff))
                                               ? 7'(count_sat) : win_eff;
                                mod_r_next    = '0;
                                mod_dvd_next  = s_tdata[12:7];
                                mod_step_next = '0;
                                state_next    = ST_MOD;
                            end
                        end
                        swarq_pkg::REQ_ACK: begin
                            if (phase_reg != swarq_pkg::PH_IDLE) begin
                                state_next = ST_ACK_RD;
                            end
                        end
                        swarq_pkg::REQ_TICK: begin
                            if (phase_reg != swarq_pkg::PH_IDLE) begin
                                pos_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_MOD: begin
                mod_dvd_next  = {mod_dvd_reg[4:0], 1'b0};
                mod_step_next = mod_step_reg + 3'd1;
                if (mod_step_reg == MOD_LAST) begin
                    if (req_reg == swarq_pkg::REQ_START) begin
                        // Everything is unsent after a start, so the scan
                        // settles on the start index itself.
                        first_idx_next = IW'(mod_r_next);
                        mem_we         = 1'b1;
                        mem_waddr      = IW'(mod_r_next);
                        mem_wdata      = 2'b01;
                        vld_next[IW'(mod_r_next)] = 1'b1;
                        phase_next     = swarq_pkg::PH_FIRST;
                        emit_go        = 1'b1;
                        emit_res       = '{swarq_pkg::ACT_SEND, 6'(mod_r_next), 16'd0, 1'b1};
                        state_next     = ST_FINISH;
                    end else begin
                        pos_next      = IW'(mod_r_next);
                        scan_cnt_next = '0;
                        state_next    = (credits_reg == 7'd0) ? ST_FINISH : ST_READ;
                    end
                end
            end

            ST_ACK_RD: begin
                rd_en      = 1'b1;
                rd_addr    = IW'(apkt_reg);
                state_next = ST_ACK_EV;
            end

            ST_ACK_EV: begin
                state_next = ST_FINISH;
                if (hit) begin
                    mem_we         = 1'b1;
                    mem_waddr      = IW'(apkt_reg);
                    mem_wdata      = {1'b1, ent_sent};
                    vld_next[IW'(apkt_reg)] = 1'b1;
                    acked_cnt_next = CW'(acked_p1);
                    tmo_next       = '0;
                    if (phase_reg == swarq_pkg::PH_FIRST) begin
                        tag_next = aid_reg;
                    end else if (credits_reg != 7'd127) begin
                        credits_next = credits_reg + 7'd1;
                    end
                    if (acked_p1 >= (CW + 1)'(total_reg)) begin
                        phase_next = swarq_pkg::PH_IDLE;
                        emit_go    = 1'b1;
                        emit_res   = '{swarq_pkg::ACT_DONE, 6'd0, tag_next, 1'b0};
                    end else begin
                        phase_next    = swarq_pkg::PH_RUN;
                        mod_r_next    = '0;
                        mod_dvd_next  = sstart_reg;
                        mod_step_next = '0;
                        state_next    = ST_MOD;
                    end
                end
            end

            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL: begin
                if (req_reg == swarq_pkg::REQ_TICK) begin
                    // Resend sweep over packets 0 .. total-1.
                    if (!(ent_sent && !ent_acked) || can_emit) begin
                        if (ent_sent && !ent_acked) begin
                            emit_go  = 1'b1;
                            emit_res = '{swarq_pkg::ACT_RESEND, 6'(pos_reg),
                                         (phase_reg == swarq_pkg::PH_FIRST) ? 16'd0 : tag_reg,
                                         (phase_reg == swarq_pkg::PH_FIRST) &&
                                         (pos_reg == first_idx_reg)};
                        end
                        if (pos_p1 == total_reg) begin
                            state_next = ST_TAIL;
                        end else begin
                            pos_next   = IW'(pos_p1);
                            state_next = ST_READ;
                        end
                    end
                end else begin
                    // Refill: circular search for an unsent packet.
                    if (!ent_sent) begin
                        if (can_emit) begin
                            mem_we        = 1'b1;
                            mem_wdata     = 2'b01;
                            vld_next[pos_reg] = 1'b1;
                            credits_next  = credits_reg - 7'd1;
                            emit_go       = 1'b1;
                            emit_res      = '{swarq_pkg::ACT_SEND, 6'(pos_reg), tag_reg, 1'b0};
                            pos_next      = pos_wrap;
                            scan_cnt_next = '0;
                            state_next    = (credits_reg == 7'd1) ? ST_FINISH : ST_READ;
                        end
                    end else begin
                        pos_next      = pos_wrap;
                        scan_cnt_next = scan_cnt_reg + CW'(1);
                        state_next    = (scan_cnt_reg + CW'(1) == total_reg) ? ST_FINISH
                                                                            : ST_READ;
                    end
                end
            end

            ST_TAIL: begin
                if (tmo_inc >= limit_reg) begin
                    if (can_emit) begin
                        tmo_next   = tmo_inc;
                        phase_next = swarq_pkg::PH_IDLE;
                        emit_go    = 1'b1;
                        emit_res   = '{swarq_pkg::ACT_FAIL, 6'd0, tag_reg, 1'b0};
                        state_next = ST_FINISH;
                    end
                end else begin
                    tmo_next   = tmo_inc;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    flush_go   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (state_reg != ST_MOD && state_reg != ST_IDLE && state_reg != ST_ACK_EV) begin
            mod_r_next = mod_r_reg;
        end

        // Output register and held result.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit_go) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end
        if (flush_go) begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= swarq_pkg::PH_IDLE;
            total_reg      <= '0;
            acked_cnt_reg  <= '0;
            credits_reg    <= '0;
            tag_reg        <= '0;
            tmo_reg        <= '0;
            first_idx_reg  <= '0;
            window_reg     <= 7'd4;
            limit_reg      <= 4'd3;
            vld_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            total_reg      <= total_next;
            acked_cnt_reg  <= acked_cnt_next;
            credits_reg    <= credits_next;
            tag_reg        <= tag_next;
            tmo_reg        <= tmo_next;
            first_idx_reg  <= first_idx_next;
            window_reg     <= window_next;
            limit_reg      <= limit_next;
            vld_reg        <= vld_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_next_hold: begin
            req_reg      <= req_next;
            sstart_reg   <= sstart_next;
            apkt_reg     <= apkt_next;
            aid_reg      <= aid_next;
            pos_reg      <= pos_next;
            scan_cnt_reg <= scan_cnt_next;
            mod_r_reg    <= mod_r_next;
            mod_dvd_reg  <= mod_dvd_next;
            mod_step_reg <= mod_step_next;
            pend_reg     <= pend_next;
            out_reg      <= out_next;
            out_last_reg <= out_last_next;
        end
    end

    // Status memory, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

`include "assert_macros.svh"

    `SWA_ASSERT(a_idle_no_held, (state_reg == ST_IDLE) |-> !pend_valid_reg, "held result left over in idle")
    `SWA_ASSERT(a_acked_bound, acked_cnt_reg <= total_reg, "acked count exceeds packet count")
    `SWA_ASSERT(a_busy_count, (phase_reg != swarq_pkg::PH_IDLE) |-> (total_reg != '0), "active message without packets")
    `SWA_ASSERT_NEXT(a_read_then_eval, state_reg == ST_READ, state_reg == ST_EVAL, "scan read not followed by evaluation")

endmodule
